[design/derb_pkg.sv]
// Shared types, constants and ring index helpers for the double-ended ring buffer.
`timescale 1ns / 1ps

package derb_pkg;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned IDX_W          = $clog2(DEPTH);
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned ACT_W          = 3;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned S_TDATA_W      = FIELD_W;
  localparam int unsigned M_FIELDS_W     = 2 * FIELD_W + CNT_W + 4;
  localparam int unsigned M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_CLEAR      = 3'd4
  } action_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] front_addr;
    logic [IDX_W-1:0] back_addr;
    logic             rd_zero;
  } mem_req_t;

  typedef struct packed {
    logic             overwrote;
    logic             underflow;
    logic             is_empty;
    logic             is_full;
    logic [CNT_W-1:0] count;
  } status_t;

  // Register value 0 acts as 1, anything above DEPTH acts as DEPTH.
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = v;
    if (c == '0) c = CNT_W'(1);
    if (c > CNT_W'(DEPTH)) c = CNT_W'(DEPTH);
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(i) + CNT_W'(1);
    return (n >= cap) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [IDX_W-1:0] dec_wrap(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] cap);
    return (i == '0) ? IDX_W'(cap - CNT_W'(1)) : i - IDX_W'(1);
  endfunction

endpackage

[design/double_ended_ring_buffer_core.sv]
// Top level of the double-ended ring buffer: stream ports, input and result registers.
//
// channel   dir  tdata                                            tuser
// s_axis    in   data_in[31:0]                                    action[2:0]
// m_axis    out  front[31:0] back[63:32] count[68:64] full[69]    -
//                empty[70] underflow[71] overwrote[72] pad[79:73]
// cfg       in   capacity_in_use[4:0] on cfg_we_i                 -
//
// One beat in and one beat out per cycle while m_axis is not stalled; a beat is held in the
// input register, then the pointer update with slot write and read registers its result.
// Reset clears pointers, count and valid flags; capacity returns to 16.
// A stalled output holds its beat; the input register takes one more beat, then
// tready stays low until the result leaves.
`timescale 1ns / 1ps

module double_ended_ring_buffer_core import derb_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,    // capacity_in_use
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i, // data_in
  input  logic [ACT_W-1:0]     s_axis_tuser_i, // action
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o  // front, back, count, full, empty,
                                               // underflow, overwrote, zero pad
);

  logic                 in_vld_q, in_vld_d;
  action_e              act_q;
  logic [FIELD_W-1:0]   data_q;
  logic                 out_vld_q, out_vld_d;
  status_t              status_q, status_d;
  logic                 advance;
  logic                 s_beat;
  mem_req_t             mem_req;
  logic [DATA_WIDTH-1:0] wdata, front_raw, back_raw;
  logic [FIELD_W-1:0]   front_val, back_val;

  assign advance         = in_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | advance;
  assign s_beat          = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_beat) in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (advance) out_vld_d = 1'b1;
    else if (m_axis_tready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      act_q  <= action_e'(s_axis_tuser_i);
      data_q <= s_axis_tdata_i;
    end
    if (advance) status_q <= status_d;
  end

  derb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .action_i    (act_q),
    .mem_req_o   (mem_req),
    .status_o    (status_d)
  );

  assign wdata = DATA_WIDTH'(data_q);

  derb_store #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .advance_i (advance),
    .req_i     (mem_req),
    .wdata_i   (wdata),
    .front_o   (front_raw),
    .back_o    (back_raw)
  );

  assign front_val = FIELD_W'(front_raw);
  assign back_val  = FIELD_W'(back_raw);

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                            status_q.overwrote, status_q.underflow,
                            status_q.is_empty, status_q.is_full, status_q.count,
                            back_val, front_val};

endmodule

[design/derb_ctrl.sv]
// Pointer, count and capacity logic for the double-ended ring buffer.
`timescale 1ns / 1ps

module derb_ctrl import derb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             advance_i,
  input  action_e          action_i,
  output mem_req_t         mem_req_o,
  output status_t          status_o
);

  logic [IDX_W-1:0] head_q, head_d, head_n;
  logic [IDX_W-1:0] tail_q, tail_d, tail_n;
  logic [CNT_W-1:0] count_q, count_d, count_n;
  logic [CNT_W-1:0] cap_q, cap_d;
  logic             full, empty, uf, ow;
  logic [IDX_W-1:0] waddr;
  logic             push;
  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] tail_chk;

  always_comb begin
    full    = (count_q >= cap_q);
    empty   = (count_q == '0);
    head_n  = head_q;
    tail_n  = tail_q;
    count_n = count_q;
    uf      = 1'b0;
    ow      = 1'b0;
    push    = 1'b0;
    waddr   = tail_q;
    unique case (action_i)
      ACT_PUSH_BACK: begin
        push   = 1'b1;
        waddr  = tail_q;
        tail_n = inc_wrap(tail_q, cap_q);
        if (full) begin
          head_n = inc_wrap(head_q, cap_q);
          ow     = 1'b1;
        end else begin
          count_n = count_q + CNT_W'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        push   = 1'b1;
        head_n = dec_wrap(head_q, cap_q);
        waddr  = head_n;
        if (full) begin
          tail_n = dec_wrap(tail_q, cap_q);
          ow     = 1'b1;
        end else begin
          count_n = count_q + CNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          uf = 1'b1;
        end else begin
          tail_n  = dec_wrap(tail_q, cap_q);
          count_n = count_q - CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          uf = 1'b1;
        end else begin
          head_n  = inc_wrap(head_q, cap_q);
          count_n = count_q - CNT_W'(1);
        end
      end
      ACT_CLEAR: begin
        head_n  = '0;
        tail_n  = '0;
        count_n = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_req_o.we         = advance_i & push;
    mem_req_o.waddr      = waddr;
    mem_req_o.front_addr = head_n;
    mem_req_o.back_addr  = dec_wrap(tail_n, cap_q);
    mem_req_o.rd_zero    = (count_n == '0);
    status_o.count       = count_n;
    status_o.is_full     = (count_n == cap_q);
    status_o.is_empty    = (count_n == '0);
    status_o.underflow   = uf;
    status_o.overwrote   = ow;
  end

  // config write empties the buffer and wins over a beat
  always_comb begin
    cap_d   = cap_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cfg_we_i) begin
      cap_d   = eff_cap(cfg_wdata_i);
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (advance_i) begin
      head_d  = head_n;
      tail_d  = tail_n;
      count_d = count_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CNT_W'(DEPTH);
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      cap_q   <= cap_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // tail sits count slots past head, modulo capacity
  always_comb begin
    tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
    if (tail_sum >= (CNT_W+1)'(cap_q)) tail_sum = tail_sum - (CNT_W+1)'(cap_q);
    tail_chk = IDX_W'(tail_sum);
  end

  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q) else $error("count above capacity");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(head_q) < cap_q) && (CNT_W'(tail_q) < cap_q))
    else $error("pointer outside capacity");

  a_tail_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == tail_chk) else $error("tail does not match head plus count");

  a_cfg_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (count_q == '0) && (head_q == '0) && (tail_q == '0))
    else $error("config write did not empty the buffer");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status_o.underflow && status_o.overwrote))
    else $error("underflow and overwrite together");

endmodule

[design/derb_store.sv]
// Slot memory with registered front and back read ports and write-through bypass.
`timescale 1ns / 1ps

module derb_store import derb_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  advance_i,
  input  mem_req_t              req_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] front_o,
  output logic [DATA_WIDTH-1:0] back_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] front_q;
  logic [DATA_WIDTH-1:0] back_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= wdata_i;
  end

  // read ports see the slot written on the same edge
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      if (req_i.rd_zero) begin
        front_q <= '0;
        back_q  <= '0;
      end else begin
        front_q <= (req_i.we && req_i.waddr == req_i.front_addr) ? wdata_i
                                                                 : mem[req_i.front_addr];
        back_q  <= (req_i.we && req_i.waddr == req_i.back_addr) ? wdata_i
                                                                : mem[req_i.back_addr];
      end
    end
  end

  assign front_o = front_q;
  assign back_o  = back_q;

endmodule

[dv/derb_result_checker.sv]
// Checker for the double-ended ring buffer: predicts each result beat and compares it.
`timescale 1ns / 1ps

module derb_result_checker import derb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // data_in
  input  logic [ACT_W-1:0]     s_axis_tuser_i,  // action
  input  logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  input  logic [M_TDATA_W-1:0] m_axis_tdata_o,  // front, back, count, full, empty,
                                                // underflow, overwrote, zero pad
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int unsigned VIEW_W = 2 * FIELD_W + CNT_W + 4;

  typedef struct packed {
    logic               overwrote;
    logic               underflow;
    logic               is_empty;
    logic               is_full;
    logic [CNT_W-1:0]   count;
    logic [FIELD_W-1:0] back_value;
    logic [FIELD_W-1:0] front_value;
  } ring_view_t;

  logic [FIELD_W-1:0] slot_q [DEPTH];
  logic [IDX_W-1:0]   head_q;
  logic [IDX_W-1:0]   tail_q;
  logic [CNT_W-1:0]   fill_q;
  logic [CNT_W-1:0]   cap_reg_q;
  ring_view_t         expected_views [$];
  int                 fail_count = 0;

  assign fail_count_o = fail_count;

  // Register value 0 acts as one slot, anything above DEPTH as DEPTH.
  function automatic int usable_slots();
    int c;
    c = int'(cap_reg_q);
    if (c == 0) c = 1;
    if (c > int'(DEPTH)) c = DEPTH;
    return c;
  endfunction

  function automatic int step_up(input int i, input int cap);
    return (i + 1 >= cap) ? 0 : i + 1;
  endfunction

  function automatic int step_down(input int i, input int cap);
    return (i == 0) ? cap - 1 : i - 1;
  endfunction

  task automatic apply_action(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] word,
                              output ring_view_t view);
    int   cap;
    int   h;
    int   t;
    int   n;
    logic full;
    logic empty;
    cap  = usable_slots();
    h    = int'(head_q);
    t    = int'(tail_q);
    n    = int'(fill_q);
    view = '0;
    if (h >= cap || t >= cap || n > cap) begin
      h = 0;
      t = 0;
      n = 0;
    end
    full  = (n >= cap);
    empty = (n == 0);
    case (act)
      ACT_PUSH_BACK: begin
        slot_q[t] = word;
        t = step_up(t, cap);
        if (full) begin
          h = step_up(h, cap);
          view.overwrote = 1'b1;
        end else begin
          n++;
        end
      end
      ACT_PUSH_FRONT: begin
        h = step_down(h, cap);
        slot_q[h] = word;
        if (full) begin
          t = step_down(t, cap);
          view.overwrote = 1'b1;
        end else begin
          n++;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          view.underflow = 1'b1;
        end else begin
          t = step_down(t, cap);
          n--;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          view.underflow = 1'b1;
        end else begin
          h = step_up(h, cap);
          n--;
        end
      end
      ACT_CLEAR: begin
        h = 0;
        t = 0;
        n = 0;
      end
      default: ;
    endcase
    if (n != 0) begin
      view.front_value = slot_q[h];
      view.back_value  = slot_q[step_down(t, cap)];
    end
    view.count    = CNT_W'(n);
    view.is_full  = (n == cap);
    view.is_empty = (n == 0);
    head_q = IDX_W'(h);
    tail_q = IDX_W'(t);
    fill_q = CNT_W'(n);
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ring_view_t want;
    ring_view_t got;
    if (!rst_ni) begin
      head_q    = '0;
      tail_q    = '0;
      fill_q    = '0;
      cap_reg_q = CNT_W'(DEPTH);
      expected_views.delete();
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = ring_view_t'(m_axis_tdata_o[VIEW_W-1:0]);
        if (expected_views.size() == 0) begin
          $error("result beat with no pending expectation: %h", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          check_field("front_value", want.front_value, got.front_value);
          check_field("back_value", want.back_value, got.back_value);
          check_field("count", FIELD_W'(want.count), FIELD_W'(got.count));
          check_field("is_full", FIELD_W'(want.is_full), FIELD_W'(got.is_full));
          check_field("is_empty", FIELD_W'(want.is_empty), FIELD_W'(got.is_empty));
          check_field("underflow", FIELD_W'(want.underflow), FIELD_W'(got.underflow));
          check_field("overwrote", FIELD_W'(want.overwrote), FIELD_W'(got.overwrote));
          check_field("pad", '0, FIELD_W'(m_axis_tdata_o[M_TDATA_W-1:VIEW_W]));
        end
      end
      if (cfg_we_i) begin
        cap_reg_q = cfg_wdata_i;
        head_q    = '0;
        tail_q    = '0;
        fill_q    = '0;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        apply_action(s_axis_tuser_i, s_axis_tdata_i, want);
        expected_views.push_back(want);
      end
    end
    pending_o = expected_views.size();
  end

endmodule

[dv/double_ended_ring_buffer_core_test.sv]
// Testbench top for the double-ended ring buffer: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module double_ended_ring_buffer_core_test;
  import derb_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SEGMENTS      = 7;
  localparam int unsigned ITEMS_PER_SEG = 250;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [ACT_W-1:0]     s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int          fail_count;
  int          pending;
  logic        fill_mode    = 1'b1;

  always #4 clk_i = ~clk_i;

  double_ended_ring_buffer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  derb_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [S_TDATA_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Alternates between filling and draining runs so full and empty both get hit.
  task automatic send_random_beat();
    int unsigned      roll;
    logic [ACT_W-1:0] act;
    logic [31:0]      word;
    if ($urandom_range(39) == 0) fill_mode = ~fill_mode;
    roll = $urandom_range(99);
    if (roll < 2) begin
      act = ACT_CLEAR;
    end else if (roll < 5) begin
      act = ACT_W'($urandom_range(7, 5));
    end else if (roll < (fill_mode ? 75 : 30)) begin
      act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    end else begin
      act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
    end
    case ($urandom_range(9))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    send_beat(act, word);
  endtask

  initial begin
    logic [CNT_W-1:0] cap_plan [SEGMENTS];
    cap_plan = '{5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2};
    cap_plan[SEGMENTS-1] = CNT_W'($urandom_range(15, 2));
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct = 10;
    snk_idle_pct = 61;

    // empty buffer at reset capacity
    send_beat(ACT_POP_BACK, 32'h1234_5678);
    send_beat(ACT_POP_FRONT, 32'hFFFF_FFFF);
    send_beat(ACT_CLEAR, 32'h0);
    send_beat(ACT_PUSH_BACK, 32'h0000_0000);
    send_beat(ACT_PUSH_BACK, 32'hFFFF_FFFF);
    send_beat(ACT_PUSH_FRONT, 32'h8000_0001);
    send_beat(ACT_W'(5), 32'hDEAD_BEEF);
    send_beat(ACT_W'(6), 32'h0);
    send_beat(ACT_W'(7), 32'hFFFF_FFFF);
    send_beat(ACT_POP_FRONT, 32'h0);
    send_beat(ACT_POP_BACK, 32'h0);
    send_beat(ACT_POP_BACK, 32'h0);
    send_beat(ACT_POP_BACK, 32'h0);
    send_beat(ACT_PUSH_FRONT, 32'h0000_0001);
    send_beat(ACT_CLEAR, 32'hFFFF_FFFF);

    // overwrite at both ends with two slots
    write_capacity(5'd2);
    send_beat(ACT_PUSH_BACK, 32'h0000_0011);
    send_beat(ACT_PUSH_BACK, 32'h0000_0022);
    send_beat(ACT_PUSH_BACK, 32'h0000_0033);
    send_beat(ACT_PUSH_FRONT, 32'h0000_0044);
    send_beat(ACT_POP_FRONT, 32'h0);
    send_beat(ACT_POP_FRONT, 32'h0);
    send_beat(ACT_POP_FRONT, 32'h0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        src_idle_pct = 10;
        snk_idle_pct = 61;
      end else if (seg < 4) begin
        src_idle_pct = 61;
        snk_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_capacity(cap_plan[seg]);
      repeat (ITEMS_PER_SEG) send_random_beat();
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
